// ===== rtl/matrix_local_minima_and_upper_abs_sum_unit_defines.svh =====
// Assertion macros for the checker file of the minima and upper sum block.
`ifndef MATRIX_LOCAL_MINIMA_AND_UPPER_ABS_SUM_UNIT_DEFINES_SVH
`define MATRIX_LOCAL_MINIMA_AND_UPPER_ABS_SUM_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLMUAS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MLMUAS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mlmuas_pkg.sv =====
// Package with the sizes, types and helpers of the minima and upper sum block.
package mlmuas_pkg;

	// Largest matrix side and element width.
	localparam int MAX_SIZE   = 16;
	localparam int ELEM_WIDTH = 16;

	// Derived and fixed widths.
	localparam int COL_W   = (MAX_SIZE > 2) ? $clog2(MAX_SIZE) : 1;
	localparam int SIDE_W  = $clog2(MAX_SIZE + 1);
	localparam int CFG_W   = 5;
	localparam int COUNT_W = 9;
	localparam int SUM_W   = 22;
	localparam int INC_W   = 3;

	// Matrix side after reset, as written to the register.
	localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(16);

	typedef logic signed [ELEM_WIDTH-1:0] elem_t;
	typedef logic [ELEM_WIDTH-1:0]        mag_t;
	typedef logic [COL_W-1:0]             col_t;
	typedef logic [SIDE_W-1:0]            side_t;

	// Clamp a written size into the supported range of sides.
	function automatic side_t clamp_side(input logic [CFG_W-1:0] value);
		int v;
		v = int'(value);
		if (v < 2) begin
			v = 2;
		end
		if (v > MAX_SIZE) begin
			v = MAX_SIZE;
		end
		return SIDE_W'(v);
	endfunction

endpackage

// ===== rtl/matrix_local_minima_and_upper_abs_sum_unit.sv =====
// Top level of the strict local minima counter and upper-triangle absolute sum.
//
// Elements of a square signed matrix arrive one per transfer on the input channel
// (in_valid, in_ready, element) in row-major order. cfg_wr_en with cfg_wr_data sets
// the side; values below 2 act as 2 and values above the largest side act as it.
// A write also discards any matrix in progress and must only be made while idle.
// After the last element of a matrix one result leaves on the output channel
// (out_valid, out_ready, minima_count, upper_abs_sum), in the cycle after that
// element's transfer. One element is taken every cycle unless stalled: each element
// needs one read of the single line buffer, issued one transfer ahead, a compare each
// way against its four already seen neighbours and one addition; the line buffer is
// a one-port-write, one-port-read memory with a registered read. Minimum flags for
// the previous and current rows sit in flip-flops, so no flush pass is needed at the
// end. Reset sets the side to 16 and clears the position and the running totals; the
// line buffer needs no clearing since every entry is written before it is read. When
// the receiver stalls, the result waits in the output register and elements keep
// being taken until the last element of the next matrix, which waits for it.
module matrix_local_minima_and_upper_abs_sum_unit
	import mlmuas_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [CFG_W-1:0]   cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  elem_t              element,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COUNT_W-1:0] minima_count,
	output logic [SUM_W-1:0]   upper_abs_sum
);

	// Position, side and running totals.
	side_t              side_q;
	col_t               row_q;
	col_t               col_q;
	logic [COUNT_W-1:0] tally_q;
	logic [SUM_W-1:0]   total_q;

	// Neighbourhood window and minimum flags of the previous and current rows.
	elem_t               left_q;
	elem_t               ul_q;
	elem_t               up_q;
	elem_t               head_q;
	logic [MAX_SIZE-1:0] pflag_q;
	logic [MAX_SIZE-1:0] cflag_q;

	// Line buffer with its registered read and write-to-read forwarding.
	elem_t line_mem [MAX_SIZE];
	elem_t line_rd_q;
	logic  fwd_q;
	elem_t fwd_data_q;

	// Output register.
	logic               out_valid_q;
	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   sum_q;

	// Combinational signals.
	logic                accept;
	side_t               side_m1;
	logic                row_last;
	logic                col_last;
	logic                mat_last;
	logic                has_l;
	logic                has_u;
	logic                has_ul;
	logic                has_ur;
	col_t                col_m1;
	col_t                rd_addr;
	elem_t               up_v;
	elem_t               ur_v;
	logic                x_lt_l, x_lt_ul, x_lt_up, x_lt_ur;
	logic                l_lt_x, ul_lt_x, up_lt_x, ur_lt_x;
	logic                x_flag;
	logic [MAX_SIZE-1:0] pflag_upd;
	logic [MAX_SIZE-1:0] cflag_upd;
	logic                fin_ul, fin_up, fin_l, fin_x;
	logic [INC_W-1:0]    inc;
	logic [COUNT_W-1:0]  tally_nxt;
	mag_t                mag;
	logic                add_en;
	logic [SUM_W-1:0]    total_nxt;
	logic [SUM_W+ELEM_WIDTH-1:0] sum_ext;

	// Position decode and handshake.
	always_comb begin
		side_m1  = side_q - side_t'(1);
		row_last = (side_t'(row_q) == side_m1);
		col_last = (side_t'(col_q) == side_m1);
		mat_last = row_last && col_last;
		in_ready = !out_valid_q || out_ready || !mat_last;
		accept   = in_valid && in_ready;
		has_l    = (col_q != '0);
		has_u    = (row_q != '0);
		has_ul   = has_l && has_u;
		has_ur   = has_u && !col_last;
		col_m1   = col_q - col_t'(1);
		rd_addr  = col_last ? col_t'(1) : (col_q + col_t'(2));
	end

	// Neighbour values: the row head comes from a register, up-right from the buffer.
	always_comb begin
		up_v = (col_q == '0) ? head_q : up_q;
		ur_v = fwd_q ? fwd_data_q : line_rd_q;
	end

	// Compares of the new element against its four already seen neighbours.
	always_comb begin
		x_lt_l  = element < left_q;
		x_lt_ul = element < ul_q;
		x_lt_up = element < up_v;
		x_lt_ur = element < ur_v;
		l_lt_x  = left_q < element;
		ul_lt_x = ul_q < element;
		up_lt_x = up_v < element;
		ur_lt_x = ur_v < element;
		x_flag  = (!has_l || x_lt_l) && (!has_ul || x_lt_ul) &&
			(!has_u || x_lt_up) && (!has_ur || x_lt_ur);
	end

	// Flag updates: each neighbour loses its flag when it is not below the element.
	always_comb begin
		for (int j = 0; j < MAX_SIZE; j++) begin
			pflag_upd[j] = pflag_q[j] &&
				!(has_ul && (j == int'(col_q) - 1) && !ul_lt_x) &&
				!(has_u && (j == int'(col_q)) && !up_lt_x) &&
				!(has_ur && (j == int'(col_q) + 1) && !ur_lt_x);
			if (j == int'(col_q)) begin
				cflag_upd[j] = x_flag;
			end else begin
				cflag_upd[j] = cflag_q[j] && !(has_l && (j == int'(col_q) - 1) && !l_lt_x);
			end
		end
	end

	// Cells whose last neighbour has now arrived are counted.
	always_comb begin
		fin_ul    = has_ul && pflag_q[col_m1] && ul_lt_x;
		fin_up    = has_u && col_last && pflag_q[col_q] && up_lt_x;
		fin_l     = row_last && has_l && cflag_q[col_m1] && l_lt_x;
		fin_x     = mat_last && x_flag;
		inc       = INC_W'(fin_ul) + INC_W'(fin_up) + INC_W'(fin_l) + INC_W'(fin_x);
		tally_nxt = tally_q + COUNT_W'(inc);
	end

	// Absolute value summed for cells above the main diagonal; the total wraps.
	always_comb begin
		mag       = element[ELEM_WIDTH-1] ? (~element + 1'b1) : element;
		add_en    = (col_q > row_q);
		sum_ext   = {{ELEM_WIDTH{1'b0}}, total_q} + {{SUM_W{1'b0}}, mag};
		total_nxt = add_en ? sum_ext[SUM_W-1:0] : total_q;
	end

	// Control state: size, position, totals, flags and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q      <= clamp_side(SIZE_RESET);
			row_q       <= '0;
			col_q       <= '0;
			tally_q     <= '0;
			total_q     <= '0;
			pflag_q     <= '0;
			cflag_q     <= '0;
			fwd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result takes the output register; otherwise a transfer empties it.
			if (!cfg_wr_en && accept && mat_last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				side_q  <= clamp_side(cfg_wr_data);
				row_q   <= '0;
				col_q   <= '0;
				tally_q <= '0;
				total_q <= '0;
			end else if (accept) begin
				fwd_q   <= (rd_addr == col_q);
				cflag_q <= cflag_upd;
				if (col_last) begin
					pflag_q <= cflag_upd;
				end else begin
					pflag_q <= pflag_upd;
				end
				if (mat_last) begin
					row_q   <= '0;
					col_q   <= '0;
					tally_q <= '0;
					total_q <= '0;
				end else if (col_last) begin
					row_q   <= row_q + col_t'(1);
					col_q   <= '0;
					tally_q <= tally_nxt;
					total_q <= total_nxt;
				end else begin
					col_q   <= col_q + col_t'(1);
					tally_q <= tally_nxt;
					total_q <= total_nxt;
				end
			end
		end
	end

	// Window shift, forwarding data and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			left_q     <= element;
			ul_q       <= up_v;
			up_q       <= ur_v;
			fwd_data_q <= element;
			if (col_q == '0) begin
				head_q <= element;
			end
			if (mat_last) begin
				count_q <= tally_nxt;
				sum_q   <= total_nxt;
			end
		end
	end

	// Line buffer: write the element at its column, read ahead for the next transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			line_mem[col_q] <= element;
			line_rd_q       <= line_mem[rd_addr];
		end
	end

	assign out_valid     = out_valid_q;
	assign minima_count  = count_q;
	assign upper_abs_sum = sum_q;

endmodule

// ===== rtl/mlmuas_checker.sv =====
// Port checker for the minima and upper sum block, bound to its top level.
`include "matrix_local_minima_and_upper_abs_sum_unit_defines.svh"

module mlmuas_checker
	import mlmuas_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [COUNT_W-1:0] minima_count,
	input logic [SUM_W-1:0]   upper_abs_sum
);

	// With no result waiting the block always takes an element.
	`MLMUAS_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

	// A result only appears after an element transfer.
	`MLMUAS_ASSERT_IMP(a_result_after_input, $rose(out_valid), $past(in_valid && in_ready), "result without input transfer")

	// The count can never exceed the number of cells.
	`MLMUAS_ASSERT_IMP(a_count_bound, out_valid, int'(minima_count) <= MAX_SIZE * MAX_SIZE, "minima count out of range")

	// A stalled result holds its value.
	`MLMUAS_ASSERT_NXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(minima_count) && $stable(upper_abs_sum), "stalled result changed")

endmodule

bind matrix_local_minima_and_upper_abs_sum_unit mlmuas_checker u_mlmuas_checker (.*);

// ===== tb/matrix_local_minima_and_upper_abs_sum_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the strict local minima and upper-triangle absolute sum block.
module matrix_local_minima_and_upper_abs_sum_unit_tb;
	import mlmuas_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 4;
	localparam int ELEMENT_GOAL  = 2000;
	localparam int REPORT_LIMIT  = 10;

	// One matrix result: minima count and upper-triangle absolute sum.
	typedef struct packed {
		logic [COUNT_W-1:0] minima;
		logic [SUM_W-1:0]   abs_sum;
	} tally_t;

	// One directed element, with an optional size write before it and an
	// optional hand-written result when it closes a matrix.
	typedef struct {
		bit               set_size;
		logic [CFG_W-1:0] size_val;
		elem_t            value;
		bit               typed;
		logic [COUNT_W-1:0] want_minima;
		logic [SUM_W-1:0]   want_sum;
	} vector_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [CFG_W-1:0]   cfg_wr_data;
	logic               in_valid;
	logic               in_ready;
	elem_t              element;
	logic               out_valid;
	logic               out_ready;
	logic [COUNT_W-1:0] minima_count;
	logic [SUM_W-1:0]   upper_abs_sum;

	matrix_local_minima_and_upper_abs_sum_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.element      (element),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.minima_count (minima_count),
		.upper_abs_sum(upper_abs_sum)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Directed elements: both clamps of the size, the element extremes,
	// ties that give no minimum, and a size write that drops a part matrix.
	vector_t vectors [24] = '{
		// Size 0 acts as 2; an all-zero matrix has no strict minimum.
		'{1'b1, 5'd0, 16'sd0, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sd0, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sd0, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sd0, 1'b1, 9'd0, 22'd0},
		// Size 1 acts as 2; the most negative corner is the only minimum.
		'{1'b1, 5'd1, 16'sh8000, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sh7FFF, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sh7FFF, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sh7FFF, 1'b1, 9'd1, 22'd32767},
		// The absolute value of the most negative element above the diagonal.
		'{1'b1, 5'd2, 16'sd5, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sh8000, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sd7, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sd9, 1'b1, 9'd1, 22'd32768},
		// Size 31 acts as 16; this part matrix is discarded by the next write.
		'{1'b1, 5'd31, 16'sd100, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, elem_t'(-5), 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sd12, 1'b0, 9'd0, 22'd0},
		// A 3x3 matrix with a single interior minimum.
		'{1'b1, 5'd3, 16'sd1, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sd2, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sd1, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sd2, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sd0, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sd2, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sd1, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sd2, 1'b0, 9'd0, 22'd0},
		'{1'b0, 5'd0, 16'sd1, 1'b0, 9'd0, 22'd0}
	};

	// Predictor state: the current frame, the raster position and the running sum.
	elem_t            frame [MAX_SIZE][MAX_SIZE];
	int               side_now;
	int               pos_row;
	int               pos_col;
	logic [SUM_W-1:0] upper_total;
	tally_t           tallies_due [$];

	int  fault_count;
	int  elements_sent;
	int  cycle_count;
	bit  steady;

	// Effective side for a written size.
	function automatic int side_of(input logic [CFG_W-1:0] v);
		int n;
		n = int'(v);
		if (n < 2) begin
			n = 2;
		end
		if (n > MAX_SIZE) begin
			n = MAX_SIZE;
		end
		return n;
	endfunction

	// Count the cells strictly below every neighbour that lies inside the matrix.
	function automatic logic [COUNT_W-1:0] count_strict_minima();
		logic [COUNT_W-1:0] hits;
		bit                 lowest;
		int                 rr;
		int                 cc;
		hits = '0;
		for (int i = 0; i < side_now; i++) begin
			for (int j = 0; j < side_now; j++) begin
				lowest = 1'b1;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						rr = i + dr;
						cc = j + dc;
						if ((dr != 0 || dc != 0) && rr >= 0 && rr < side_now &&
								cc >= 0 && cc < side_now) begin
							if (!(frame[i][j] < frame[rr][cc])) begin
								lowest = 1'b0;
							end
						end
					end
				end
				if (lowest) begin
					hits = hits + 1'b1;
				end
			end
		end
		return hits;
	endfunction

	// A size write sets the side and drops any matrix in progress.
	task automatic apply_size(input logic [CFG_W-1:0] v);
		side_now    = side_of(v);
		pos_row     = 0;
		pos_col     = 0;
		upper_total = '0;
	endtask

	// Take one element into the predictor; a result is due when the matrix closes.
	task automatic absorb_element(input elem_t v, output bit complete, output tally_t t);
		int mag;
		mag = (v < 0) ? -int'(v) : int'(v);
		frame[pos_row][pos_col] = v;
		if (pos_col > pos_row) begin
			upper_total = upper_total + SUM_W'(mag);
		end
		pos_col++;
		if (pos_col >= side_now) begin
			pos_col = 0;
			pos_row++;
		end
		complete = (pos_row >= side_now);
		t = '0;
		if (complete) begin
			t.minima  = count_strict_minima();
			t.abs_sum = upper_total;
			pos_row     = 0;
			pos_col     = 0;
			upper_total = '0;
		end
	endtask

	// Mostly no gap or a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Element values: small ones for ties, full range, extremes and a middle band.
	function automatic elem_t random_element();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			return elem_t'(int'($urandom_range(0, 6)) - 3);
		end else if (r < 75) begin
			return elem_t'($urandom);
		end else if (r < 88) begin
			case ($urandom_range(0, 3))
				0: return 16'sh8000;
				1: return 16'sh7FFF;
				2: return elem_t'(-1);
				default: return 16'sd0;
			endcase
		end
		return elem_t'(int'($urandom_range(0, 200)) - 100);
	endfunction

	// Mostly small sides, a few mid-sized and full ones, and any written value.
	function automatic logic [CFG_W-1:0] choose_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return CFG_W'($urandom_range(2, 6));
		end else if (r < 85) begin
			return CFG_W'($urandom_range(0, 31));
		end else if (r < 94) begin
			return CFG_W'($urandom_range(7, 12));
		end
		return ($urandom_range(0, 1) == 0) ? CFG_W'(16) : CFG_W'(17);
	endfunction

	task automatic note_fault(input string what, input int want, input int got);
		fault_count++;
		if (fault_count <= REPORT_LIMIT) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// One input transfer; the valid stays high into the next element unless a gap follows.
	task automatic send_element(input elem_t v, input int gap, input bit typed,
			input tally_t want);
		bit     complete;
		tally_t t;
		@(negedge clk);
		in_valid <= 1'b1;
		element  <= v;
		do @(posedge clk); while (!in_ready);
		absorb_element(v, complete, t);
		if (complete) begin
			tallies_due.push_back(typed ? want : t);
		end
		elements_sent++;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Hold off the sender until every result is in and the block has settled, then write.
	task automatic settle_and_write(input logic [CFG_W-1:0] v);
		@(negedge clk);
		in_valid <= 1'b0;
		while (tallies_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		apply_size(v);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Result checker: each transfer against the oldest expectation.
	always @(posedge clk) begin : result_check
		tally_t want;
		if (arst_n && out_valid && out_ready) begin
			if (tallies_due.size() == 0) begin
				note_fault("unexpected result, minima", -1, int'(minima_count));
			end else begin
				want = tallies_due.pop_front();
				if (minima_count !== want.minima) begin
					note_fault("minima_count", int'(want.minima), int'(minima_count));
				end
				if (upper_abs_sum !== want.abs_sum) begin
					note_fault("upper_abs_sum", int'(want.abs_sum), int'(upper_abs_sum));
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: ready stretches broken by stalls, mostly short and a few long.
	initial begin : receiver
		int ready_len;
		int stall_len;
		int r;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			r = $urandom_range(0, 99);
			ready_len = (r < 15) ? $urandom_range(50, 200) : $urandom_range(1, 6);
			r = $urandom_range(0, 99);
			stall_len = (r < 40) ? 0 : (r < 90) ? $urandom_range(1, 4) : $urandom_range(10, 40);
			out_ready <= 1'b1;
			repeat (ready_len) @(negedge clk);
			if (stall_len > 0) begin
				out_ready <= 1'b0;
				repeat (stall_len) @(negedge clk);
			end
		end
	end

	// Stimulus: a matrix at the reset size, the directed table, then random phases.
	initial begin : stimulus
		int     mats;
		int     tail;
		tally_t want;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		element       = '0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		fault_count   = 0;
		elements_sent = 0;
		cycle_count   = 0;
		steady        = 1'b0;
		apply_size(SIZE_RESET);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The side after reset is the largest one.
		for (int k = 0; k < side_now * side_now; k++) begin
			send_element(random_element(), pick_gap(), 1'b0, '0);
		end

		foreach (vectors[k]) begin
			if (vectors[k].set_size) begin
				settle_and_write(vectors[k].size_val);
			end
			want.minima  = vectors[k].want_minima;
			want.abs_sum = vectors[k].want_sum;
			send_element(vectors[k].value, pick_gap(), vectors[k].typed, want);
		end

		// Each phase: a size write, whole matrices, sometimes a part matrix to discard.
		while (elements_sent < ELEMENT_GOAL) begin
			settle_and_write(choose_size());
			steady = ($urandom_range(0, 4) == 0);
			mats = $urandom_range(1, 3);
			repeat (mats * side_now * side_now) begin
				send_element(random_element(), pick_gap(), 1'b0, '0);
			end
			if ($urandom_range(0, 9) < 3) begin
				tail = $urandom_range(1, side_now * side_now - 1);
				repeat (tail) send_element(random_element(), pick_gap(), 1'b0, '0);
			end
		end

		// Drain the remaining results.
		@(negedge clk);
		in_valid <= 1'b0;
		while (tallies_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		if (fault_count == 0 && tallies_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
